### rtl/hri_pkg.sv
package hri_pkg;

  localparam int CHUNK_W = 16;
  localparam int BASE_W  = 9;

  localparam logic [BASE_W-1:0] PRIMES [64] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PROD,
    ST_CORR,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic mul_first;
    logic prod;
    logic corr;
    logic div;
  } cmd_t;

  typedef struct packed {
    logic last_digit;
  } status_t;

  // floor(2^mw / b) by restoring division, elaboration use only
  function automatic logic [63:0] recip_fn(input logic [BASE_W-1:0] b, input int mw);
    logic [BASE_W:0] rem;
    logic [63:0]     q;
    rem = (BASE_W+1)'(1);
    q   = '0;
    for (int i = 0; i < 64; i++) begin
      if (i < mw) begin
        rem = {rem[BASE_W-1:0], 1'b0};
        q   = {q[62:0], 1'b0};
        if (rem >= {1'b0, b}) begin
          rem  = rem - {1'b0, b};
          q[0] = 1'b1;
        end
      end
    end
    return q;
  endfunction

endpackage

### rtl/halton_radical_inverse_top.sv
// Halton radical inverse: one request gives one 32-bit fraction.
// Input: in_sample_index and in_dimension are taken at a rising edge with
// start high and busy low. The base is the prime picked by in_dimension;
// dimensions at or beyond NUM_DIMS use base 2. index+1 is written in that base
// and mirrored about the radix point, then scaled to FRAC_BITS bits, truncated.
// Output: out_fraction is valid for exactly one cycle while out_valid is high;
// the receiver cannot stall, so nothing is ever held back.
// Steps: the reciprocal is split into NC = ceil((INDEX_BITS+1)/16) chunks.
// Each base digit of index+1 takes the multiply of index by the reciprocal,
// 16 bits of the reciprocal per cycle, then the back multiply and the
// correction; the final scaling is a restoring division at one bit per
// cycle. busy drops in the result cycle, so the next request can be taken
// at the edge that ends it.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// busy and out_valid; any request in progress is lost.
module halton_radical_inverse_top
  import hri_pkg::*;
#(
  parameter int NUM_DIMS   = 16,
  parameter int INDEX_BITS = 32,
  parameter int FRAC_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_sample_index,
  input  logic [3:0]  in_dimension,
  output logic        out_valid,
  output logic [31:0] out_fraction
);

  cmd_t    cmd;
  status_t status;

  hri_ctrl #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  hri_dp #(
    .NUM_DIMS   (NUM_DIMS),
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .in_sample_index (in_sample_index),
    .in_dimension    (in_dimension),
    .status          (status),
    .out_fraction    (out_fraction)
  );

endmodule

### rtl/hri_ctrl.sv
module hri_ctrl
  import hri_pkg::*;
#(
  parameter int INDEX_BITS = 32,
  parameter int FRAC_BITS  = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid
);

  localparam int NB = INDEX_BITS + 1;
  localparam int NC = (NB + CHUNK_W - 1) / CHUNK_W;
  localparam int CW = $clog2(FRAC_BITS);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            take;

  assign take = start && ((state_r == ST_IDLE) || (state_r == ST_DONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE, ST_DONE: begin
        if (take) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
        cnt_nxt = '0;
      end
      ST_MUL: begin
        if (cnt_r == CW'(NC - 1)) begin
          state_nxt = ST_PROD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_PROD: begin
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        state_nxt = status.last_digit ? ST_DIV : ST_MUL;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == CW'(FRAC_BITS - 1)) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = take;
    cmd.mul       = (state_r == ST_MUL);
    cmd.mul_first = (state_r == ST_MUL) && (cnt_r == '0);
    cmd.prod      = (state_r == ST_PROD);
    cmd.corr      = (state_r == ST_CORR);
    cmd.div       = (state_r == ST_DIV);
    busy          = !((state_r == ST_IDLE) || (state_r == ST_DONE));
    out_valid     = (state_r == ST_DONE);
  end

endmodule

### rtl/hri_dp.sv
module hri_dp
  import hri_pkg::*;
#(
  parameter int NUM_DIMS   = 16,
  parameter int INDEX_BITS = 32,
  parameter int FRAC_BITS  = 32
) (
  input  logic        clk,
  input  cmd_t        cmd,
  input  logic [31:0] in_sample_index,
  input  logic [3:0]  in_dimension,
  output status_t     status,
  output logic [31:0] out_fraction
);

  localparam int NB = INDEX_BITS + 1;
  localparam int NC = (NB + CHUNK_W - 1) / CHUNK_W;
  localparam int MW = NC * CHUNK_W;
  localparam int AW = NB + CHUNK_W + 1;
  localparam int QW = NB + BASE_W;
  localparam int DW = INDEX_BITS + BASE_W;
  localparam int UB = (INDEX_BITS < 32) ? INDEX_BITS : 32;

  logic [BASE_W-1:0] base_tab [16];
  logic [MW-1:0]     rcp_tab  [16];

  for (genvar d = 0; d < 16; d++) begin : g_tab
    localparam logic [BASE_W-1:0] B = (d < NUM_DIMS) ? PRIMES[d] : PRIMES[0];
    assign base_tab[d] = B;
    assign rcp_tab[d]  = MW'(recip_fn(B, MW));
  end

  logic [NB-1:0]        n_r;
  logic [BASE_W-1:0]    base_r;
  logic [MW-1:0]        rcp_r, msh_r;
  logic [AW-1:0]        acc_r;
  logic [QW-1:0]        qb_r;
  logic [DW-1:0]        rev_r, den_r;
  logic [FRAC_BITS-1:0] q_r;

  logic [CHUNK_W-1:0]    chunk;
  logic [NB+CHUNK_W-1:0] nm;
  logic [AW-1:0]         acc_nxt;
  logic [NB-1:0]         qp, q_fix;
  logic [QW-1:0]         diff;
  logic [BASE_W:0]       r, r_sub;
  logic                  ge;
  logic [BASE_W-1:0]     digit;
  logic [DW:0]           sh, sh_sub;
  logic                  ge_div;

  // quotient estimate by reciprocal, one chunk of the reciprocal per cycle
  assign chunk   = cmd.mul_first ? rcp_r[CHUNK_W-1:0] : msh_r[CHUNK_W-1:0];
  assign nm      = (NB+CHUNK_W)'(n_r) * (NB+CHUNK_W)'(chunk);
  assign acc_nxt = (cmd.mul_first ? '0 : (acc_r >> CHUNK_W)) + AW'(nm);
  assign qp      = acc_r[NB+CHUNK_W-1:CHUNK_W];

  // estimate is at most one low; fix it and take the digit
  assign diff  = QW'(n_r) - qb_r;
  assign r     = diff[BASE_W:0];
  assign r_sub = r - {1'b0, base_r};
  assign ge    = (r >= {1'b0, base_r});
  assign digit = ge ? r_sub[BASE_W-1:0] : r[BASE_W-1:0];
  assign q_fix = qp + NB'(ge);

  assign status.last_digit = (q_fix == '0);

  assign sh     = {rev_r, 1'b0};
  assign sh_sub = sh - {1'b0, den_r};
  assign ge_div = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= NB'(in_sample_index[UB-1:0]) + NB'(1);
      base_r <= base_tab[in_dimension];
      rcp_r  <= rcp_tab[in_dimension];
      rev_r  <= '0;
      den_r  <= DW'(1);
      q_r    <= '0;
    end
    if (cmd.mul) begin
      acc_r <= acc_nxt;
      msh_r <= (cmd.mul_first ? rcp_r : msh_r) >> CHUNK_W;
    end
    if (cmd.prod) begin
      qb_r <= QW'(qp) * QW'(base_r);
    end
    if (cmd.corr) begin
      n_r   <= q_fix;
      rev_r <= rev_r * DW'(base_r) + DW'(digit);
      den_r <= den_r * DW'(base_r);
    end
    if (cmd.div) begin
      rev_r <= ge_div ? sh_sub[DW-1:0] : sh[DW-1:0];
      q_r   <= {q_r[FRAC_BITS-2:0], ge_div};
    end
  end

  assign out_fraction = 32'(q_r);

endmodule
